### hw/rtl/tlp_pkg.sv
package tlp_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int DIR_FRAC    = 30;
  localparam int DIR_WIDTH   = DIR_FRAC + 1;
  localparam int PROD_WIDTH  = 2 * COORD_WIDTH;
  localparam int SPEED_WIDTH = 24;
  localparam int TIME_WIDTH  = 16;
  localparam int STEP_WIDTH  = 20;
  localparam int CFG_WIDTH   = 24;
  localparam int IDX_WIDTH   = 3;
  localparam int NUM_AXES    = 3;
  localparam int SQRT_STEPS  = COORD_WIDTH;
  localparam int CNT_WIDTH   = $clog2(SQRT_STEPS + 1);

  localparam logic [IDX_WIDTH-1:0] REG_ACCEL_LIMIT = 3'd0;
  localparam logic [IDX_WIDTH-1:0] REG_SPEED_LIMIT = 3'd1;
  localparam logic [IDX_WIDTH-1:0] REG_STEP_TIME   = 3'd2;
  localparam logic [IDX_WIDTH-1:0] REG_ARRIVE_TOL  = 3'd3;
  localparam logic [IDX_WIDTH-1:0] REG_STEP_LIMIT  = 3'd4;

  typedef enum logic [2:0] {
    MOP_NONE,
    MOP_SQ,
    MOP_LHS,
    MOP_SPSQ,
    MOP_DV,
    MOP_STP,
    MOP_POS
  } mop_t;

  typedef struct packed {
    logic       capture;
    logic       load;
    mop_t       mop;
    logic [1:0] axis;
    logic       acc_sq;
    logic       sqrt_init;
    logic       sqrt_step;
    logic       div_init;
    logic       div_step;
    logic       div_store;
    logic       load_set;
    logic       tick_upd;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic move_done;
  } stat_t;

endpackage

### hw/rtl/tlp_ctrl.sv
module tlp_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_mode,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  tlp_pkg::stat_t stat,
  output tlp_pkg::cmd_t  cmd
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_SQ   = 9'b000000010,
    S_SQRT = 9'b000000100,
    S_DIV  = 9'b000001000,
    S_LSET = 9'b000010000,
    S_TMUL = 9'b000100000,
    S_TUPD = 9'b001000000,
    S_EMUL = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

  localparam logic [tlp_pkg::CNT_WIDTH-1:0] CNT_SQRT_END =
    tlp_pkg::CNT_WIDTH'(tlp_pkg::SQRT_STEPS);
  localparam logic [tlp_pkg::CNT_WIDTH-1:0] CNT_DIV_END =
    tlp_pkg::CNT_WIDTH'(tlp_pkg::DIR_WIDTH + 1);
  localparam logic [tlp_pkg::CNT_WIDTH-1:0] CNT_AXES =
    tlp_pkg::CNT_WIDTH'(tlp_pkg::NUM_AXES);
  localparam logic [1:0] LAST_AXIS = 2'(tlp_pkg::NUM_AXES - 1);

  state_t                          state_r, state_nxt;
  logic [tlp_pkg::CNT_WIDTH-1:0]   cnt_r, cnt_nxt;
  logic [1:0]                      axis_r, axis_nxt;
  logic                            out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      axis_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      axis_r      <= axis_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    cmd.mop       = tlp_pkg::MOP_NONE;
    cmd.axis      = axis_r;
    in_ready      = 1'b0;
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    axis_nxt      = axis_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          cmd.load    = !in_mode;
          cnt_nxt     = '0;
          axis_nxt    = '0;
          if (!in_mode) begin
            state_nxt = S_SQ;
          end else if (stat.move_done) begin
            state_nxt = S_EMUL;
          end else begin
            state_nxt = S_TMUL;
          end
        end
      end
      S_SQ: begin
        if (cnt_r < CNT_AXES) begin
          cmd.mop  = tlp_pkg::MOP_SQ;
          cmd.axis = cnt_r[1:0];
        end
        cmd.acc_sq = (cnt_r != '0);
        if (cnt_r == CNT_AXES) begin
          cnt_nxt   = '0;
          state_nxt = S_SQRT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_SQRT: begin
        cmd.sqrt_init = (cnt_r == '0);
        cmd.sqrt_step = (cnt_r != '0);
        if (cnt_r == CNT_SQRT_END) begin
          cnt_nxt   = '0;
          axis_nxt  = '0;
          state_nxt = S_DIV;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DIV: begin
        cmd.div_init  = (cnt_r == '0);
        cmd.div_store = (cnt_r == CNT_DIV_END);
        cmd.div_step  = (cnt_r != '0) && (cnt_r != CNT_DIV_END);
        if (cnt_r == CNT_DIV_END) begin
          cnt_nxt = '0;
          if (axis_r == LAST_AXIS) begin
            state_nxt = S_LSET;
          end else begin
            axis_nxt = axis_r + 1'b1;
          end
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_LSET: begin
        cmd.load_set = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_EMUL;
      end
      S_TMUL: begin
        unique case (cnt_r[1:0])
          2'd0:    cmd.mop = tlp_pkg::MOP_LHS;
          2'd1:    cmd.mop = tlp_pkg::MOP_SPSQ;
          2'd2:    cmd.mop = tlp_pkg::MOP_DV;
          default: cmd.mop = tlp_pkg::MOP_STP;
        endcase
        if (cnt_r[1:0] == 2'd3) begin
          cnt_nxt   = '0;
          state_nxt = S_TUPD;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_TUPD: begin
        cmd.tick_upd = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_EMUL;
      end
      S_EMUL: begin
        cmd.mop  = tlp_pkg::MOP_POS;
        cmd.axis = cnt_r[1:0];
        if (cnt_r[1:0] == LAST_AXIS) begin
          cnt_nxt   = '0;
          state_nxt = S_OUT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

### hw/rtl/tlp_dpath.sv
module tlp_dpath (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [tlp_pkg::IDX_WIDTH-1:0]         cfg_index,
  input  logic [tlp_pkg::CFG_WIDTH-1:0]         cfg_wdata,
  input  logic signed [tlp_pkg::COORD_WIDTH-1:0] in_target_x,
  input  logic signed [tlp_pkg::COORD_WIDTH-1:0] in_target_y,
  input  logic signed [tlp_pkg::COORD_WIDTH-1:0] in_target_z,
  input  tlp_pkg::cmd_t                         cmd,
  output tlp_pkg::stat_t                        stat,
  output logic signed [tlp_pkg::COORD_WIDTH-1:0] out_pos_x,
  output logic signed [tlp_pkg::COORD_WIDTH-1:0] out_pos_y,
  output logic signed [tlp_pkg::COORD_WIDTH-1:0] out_pos_z,
  output logic [tlp_pkg::SPEED_WIDTH-1:0]       out_speed_out,
  output logic                                  out_arrived,
  output logic                                  out_timed_out
);

  localparam int CW = tlp_pkg::COORD_WIDTH;
  localparam int MW = tlp_pkg::PROD_WIDTH;
  localparam int DW = tlp_pkg::DIR_WIDTH;
  localparam int SW = tlp_pkg::SPEED_WIDTH;
  localparam int TW = tlp_pkg::TIME_WIDTH;
  localparam int NW = tlp_pkg::STEP_WIDTH;

  logic [SW-1:0] accel_r, vmax_r, tol_r;
  logic [TW-1:0] dt_r;
  logic [NW-1:0] nlim_r;

  logic [CW-1:0] tgt_r [tlp_pkg::NUM_AXES];
  logic [CW-1:0] mag_r [tlp_pkg::NUM_AXES];
  logic [2:0]    neg_r;
  logic [DW-1:0] dir_mag_r [tlp_pkg::NUM_AXES];
  logic [2:0]    dir_neg_r;

  logic [CW-1:0] trav_r, path_r;
  logic [SW-1:0] speed_r;
  logic [NW-1:0] step_r;
  logic          done_r;

  logic [MW-1:0] sq_r, sum_r, lhs_r, spsq_r;
  logic [SW-1:0] dv_r, stp_r;
  logic [CW-1:0] pos_r [tlp_pkg::NUM_AXES];

  logic [MW-1:0] rad_r;
  logic [CW-1:0] root_r;
  logic [CW:0]   srem_r;
  logic [CW:0]   drem_r;
  logic [DW-1:0] quo_r;

  logic [CW-1:0] mul_a, mul_b;
  logic [MW-1:0] prod;
  logic [CW-1:0] tin [tlp_pkg::NUM_AXES];

  logic [CW+2:0] srem_sh, strial;
  logic          sge;
  logic          dge;
  logic [CW:0]   dsub;

  logic [CW-1:0] remain;
  logic          arrive_now;
  logic [NW-1:0] step_inc;
  logic          timeout;
  logic [CW:0]   nt;
  logic [CW-1:0] trav_new;
  logic [SW:0]   sinc, sval;
  logic [SW-1:0] sdec, sclamp;

  assign tin[0] = in_target_x;
  assign tin[1] = in_target_y;
  assign tin[2] = in_target_z;

  assign stat.move_done = done_r;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.mop)
      tlp_pkg::MOP_SQ: begin
        mul_a = mag_r[cmd.axis];
        mul_b = mag_r[cmd.axis];
      end
      tlp_pkg::MOP_LHS: begin
        mul_a = CW'({accel_r, 1'b0});
        mul_b = path_r - trav_r;
      end
      tlp_pkg::MOP_SPSQ: begin
        mul_a = CW'(speed_r);
        mul_b = CW'(speed_r);
      end
      tlp_pkg::MOP_DV: begin
        mul_a = CW'(accel_r);
        mul_b = CW'(dt_r);
      end
      tlp_pkg::MOP_STP: begin
        mul_a = CW'(speed_r);
        mul_b = CW'(dt_r);
      end
      tlp_pkg::MOP_POS: begin
        mul_a = trav_r;
        mul_b = CW'(dir_mag_r[cmd.axis]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = MW'(mul_a) * MW'(mul_b);

  // square root, two radicand bits per step
  assign srem_sh = {srem_r, rad_r[MW-1 -: 2]};
  assign strial  = (CW+3)'({root_r, 2'b01});
  assign sge     = (srem_sh >= strial);

  // scaled division, one quotient bit per step
  assign dge  = (drem_r >= {1'b0, root_r});
  assign dsub = dge ? (drem_r - {1'b0, root_r}) : drem_r;

  // tick update
  always_comb begin
    remain     = path_r - trav_r;
    arrive_now = (remain < CW'(tol_r));
    step_inc   = (&step_r) ? step_r : step_r + 1'b1;
    timeout    = (step_inc >= nlim_r);
    nt         = {1'b0, trav_r} + (CW+1)'(stp_r);
    trav_new   = (nt > {1'b0, path_r}) ? path_r : nt[CW-1:0];
    sinc       = {1'b0, speed_r} + {1'b0, dv_r};
    sdec       = (dv_r >= speed_r) ? '0 : speed_r - dv_r;
    sval       = (lhs_r > spsq_r) ? sinc : {1'b0, sdec};
    sclamp     = (sval > {1'b0, vmax_r}) ? vmax_r : sval[SW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_r <= SW'(655360);
      vmax_r  <= SW'(131072);
      dt_r    <= TW'(655);
      tol_r   <= SW'(655);
      nlim_r  <= NW'(100000);
    end else if (cfg_we) begin
      unique case (cfg_index)
        tlp_pkg::REG_ACCEL_LIMIT: accel_r <= cfg_wdata;
        tlp_pkg::REG_SPEED_LIMIT: vmax_r  <= cfg_wdata;
        tlp_pkg::REG_STEP_TIME:   dt_r    <= cfg_wdata[TW-1:0];
        tlp_pkg::REG_ARRIVE_TOL:  tol_r   <= cfg_wdata;
        tlp_pkg::REG_STEP_LIMIT:  nlim_r  <= cfg_wdata[NW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < tlp_pkg::NUM_AXES; i++) begin
        tgt_r[i]     <= '0;
        dir_mag_r[i] <= '0;
      end
      dir_neg_r <= '0;
      trav_r    <= '0;
      path_r    <= '0;
      speed_r   <= '0;
      step_r    <= '0;
      done_r    <= 1'b1;
    end else begin
      if (cmd.capture && cmd.load) begin
        for (int i = 0; i < tlp_pkg::NUM_AXES; i++) begin
          tgt_r[i] <= tin[i];
        end
      end
      if (cmd.div_store) begin
        dir_mag_r[cmd.axis] <= (root_r == '0) ? '0 : quo_r;
        dir_neg_r[cmd.axis] <= neg_r[cmd.axis];
      end
      if (cmd.load_set) begin
        path_r  <= root_r;
        trav_r  <= '0;
        speed_r <= '0;
        step_r  <= '0;
        done_r  <= 1'b0;
      end
      if (cmd.tick_upd) begin
        step_r <= step_inc;
        if (arrive_now) begin
          trav_r  <= path_r;
          speed_r <= '0;
          done_r  <= 1'b1;
        end else begin
          trav_r  <= trav_new;
          speed_r <= timeout ? '0 : sclamp;
          if (timeout) begin
            done_r <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture && cmd.load) begin
      for (int i = 0; i < tlp_pkg::NUM_AXES; i++) begin
        mag_r[i] <= tin[i][CW-1] ? (~tin[i] + 1'b1) : tin[i];
        neg_r[i] <= tin[i][CW-1];
      end
      sum_r <= '0;
    end
    if (cmd.acc_sq) begin
      sum_r <= sum_r + sq_r;
    end
    unique case (cmd.mop)
      tlp_pkg::MOP_SQ:   sq_r   <= prod;
      tlp_pkg::MOP_LHS:  lhs_r  <= prod;
      tlp_pkg::MOP_SPSQ: spsq_r <= prod;
      tlp_pkg::MOP_DV:   dv_r   <= prod[TW +: SW];
      tlp_pkg::MOP_STP:  stp_r  <= prod[TW +: SW];
      tlp_pkg::MOP_POS:  pos_r[cmd.axis] <= prod[tlp_pkg::DIR_FRAC +: CW];
      default: ;
    endcase
    if (cmd.sqrt_init) begin
      rad_r  <= sum_r;
      root_r <= '0;
      srem_r <= '0;
    end else if (cmd.sqrt_step) begin
      rad_r  <= {rad_r[MW-3:0], 2'b00};
      root_r <= {root_r[CW-2:0], sge};
      srem_r <= sge ? (CW+1)'(srem_sh - strial) : srem_sh[CW:0];
    end
    if (cmd.div_init) begin
      drem_r <= {1'b0, mag_r[cmd.axis]};
      quo_r  <= '0;
    end else if (cmd.div_step) begin
      drem_r <= {dsub[CW-1:0], 1'b0};
      quo_r  <= {quo_r[DW-2:0], dge};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_pos_x     <= (trav_r >= path_r) ? tgt_r[0] :
                       dir_neg_r[0] ? (~pos_r[0] + 1'b1) : pos_r[0];
      out_pos_y     <= (trav_r >= path_r) ? tgt_r[1] :
                       dir_neg_r[1] ? (~pos_r[1] + 1'b1) : pos_r[1];
      out_pos_z     <= (trav_r >= path_r) ? tgt_r[2] :
                       dir_neg_r[2] ? (~pos_r[2] + 1'b1) : pos_r[2];
      out_speed_out <= speed_r;
      out_arrived   <= ((path_r - trav_r) < CW'(tol_r));
      out_timed_out <= (step_r >= nlim_r);
    end
  end

endmodule

### hw/rtl/trapezoidal_line_profile.sv
// Straight-line trapezoidal setpoint generator, signed Q16.16. A load transaction
// (mode 0) squares the three coordinates on the shared 32x32 multiplier, takes the
// bit-pair square root of their sum and runs three bit-serial direction divisions.
// A tick transaction (mode 1) runs four multiplies and three position multiplies on
// that one multiplier; once the move has ended it runs only the three position
// multiplies. One transaction is in work at a time; a new one is taken while the
// previous result still waits in the output register.
module trapezoidal_line_profile (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [tlp_pkg::IDX_WIDTH-1:0]          cfg_index,
  input  logic [tlp_pkg::CFG_WIDTH-1:0]          cfg_wdata,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   in_mode,
  input  logic signed [tlp_pkg::COORD_WIDTH-1:0] in_target_x,
  input  logic signed [tlp_pkg::COORD_WIDTH-1:0] in_target_y,
  input  logic signed [tlp_pkg::COORD_WIDTH-1:0] in_target_z,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [tlp_pkg::COORD_WIDTH-1:0] out_pos_x,
  output logic signed [tlp_pkg::COORD_WIDTH-1:0] out_pos_y,
  output logic signed [tlp_pkg::COORD_WIDTH-1:0] out_pos_z,
  output logic [tlp_pkg::SPEED_WIDTH-1:0]        out_speed_out,
  output logic                                   out_arrived,
  output logic                                   out_timed_out
);

  tlp_pkg::cmd_t  cmd;
  tlp_pkg::stat_t stat;

  tlp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_mode   (in_mode),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tlp_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_target_x   (in_target_x),
    .in_target_y   (in_target_y),
    .in_target_z   (in_target_z),
    .cmd           (cmd),
    .stat          (stat),
    .out_pos_x     (out_pos_x),
    .out_pos_y     (out_pos_y),
    .out_pos_z     (out_pos_z),
    .out_speed_out (out_speed_out),
    .out_arrived   (out_arrived),
    .out_timed_out (out_timed_out)
  );

endmodule

### hw/rtl/tlp_checker.sv
module tlp_checker (
  input logic                                   clk,
  input logic                                   rst_n,
  input logic                                   in_valid,
  input logic                                   in_ready,
  input logic                                   out_valid,
  input logic                                   out_ready,
  input logic signed [tlp_pkg::COORD_WIDTH-1:0] out_pos_x,
  input logic [tlp_pkg::SPEED_WIDTH-1:0]        out_speed_out
);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken while busy");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pos_x) && $stable(out_speed_out))
    else $error("stalled result changed");

endmodule

bind trapezoidal_line_profile tlp_checker u_tlp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_pos_x     (out_pos_x),
  .out_speed_out (out_speed_out)
);

### tb/tb_trapezoidal_line_profile.sv
module tb_trapezoidal_line_profile;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 2000000;
  localparam int SETTLE_CYCLES = 160;
  localparam logic [tlp_pkg::IDX_WIDTH-1:0] REG_FIRST_UNUSED = 3'd5;

  typedef struct {
    bit                            mode;
    bit [tlp_pkg::COORD_WIDTH-1:0] x, y, z;
  } motion_cmd_t;

  typedef struct {
    bit [tlp_pkg::COORD_WIDTH-1:0] px, py, pz;
    bit [tlp_pkg::SPEED_WIDTH-1:0] speed;
    bit                            arrived, timed_out;
  } setpoint_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [tlp_pkg::IDX_WIDTH-1:0] cfg_index = '0;
  logic [tlp_pkg::CFG_WIDTH-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_mode = 1'b0;
  logic signed [tlp_pkg::COORD_WIDTH-1:0] in_target_x = '0, in_target_y = '0, in_target_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [tlp_pkg::COORD_WIDTH-1:0] out_pos_x, out_pos_y, out_pos_z;
  logic [tlp_pkg::SPEED_WIDTH-1:0] out_speed_out;
  logic out_arrived, out_timed_out;

  motion_cmd_t cmd_q[$];
  setpoint_t   setpoint_q[$];
  int errors = 0;
  int cycles = 0;
  int send_gap = 0;
  int recv_stall = 0;
  bit quiet = 1'b0;

  // profile state and register copies
  logic [63:0] accel_lim, speed_lim, dt, tol, step_lim;
  logic [63:0] travelled, speed_now, path_len, step_cnt;
  logic [63:0] dir_mag[3], tgt[3];
  bit dir_neg[3];
  bit move_done;

  trapezoidal_line_profile dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) cycles <= cycles + 1;

  always @(posedge clk) begin
    if (cycles > LIMIT_CYCLES) begin
      $display("trapezoidal_line_profile regression: fail");
      $finish;
    end
  end

  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] t;
    logic [127:0] sq;
    r = 0;
    for (int b = 33; b >= 0; b--) begin
      t = r | (64'd1 << b);
      sq = t * t;
      if (sq <= {64'd0, v}) r = t;
    end
    return r;
  endfunction

  function automatic setpoint_t advance_profile(bit mode, logic [31:0] x, logic [31:0] y,
                                                logic [31:0] z);
    logic [63:0] raw[3];
    logic [63:0] sum, remaining, lhs, rhs, dv, nt, m;
    setpoint_t res;
    raw[0] = x;
    raw[1] = y;
    raw[2] = z;
    if (!mode) begin
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        tgt[i] = raw[i];
        dir_neg[i] = raw[i][31];
        dir_mag[i] = raw[i][31] ? ((64'h1_0000_0000 - raw[i]) & 64'hFFFF_FFFF) : raw[i];
        sum = sum + dir_mag[i] * dir_mag[i];
      end
      path_len = floor_sqrt(sum) & 64'hFFFF_FFFF;
      for (int i = 0; i < 3; i++)
        dir_mag[i] = (path_len == 0) ? 64'd0 : (dir_mag[i] << 30) / path_len;
      travelled = 0;
      speed_now = 0;
      step_cnt = 0;
      move_done = 1'b0;
    end else if (!move_done) begin
      remaining = path_len - travelled;
      if (step_cnt < 64'hFFFFF) step_cnt = step_cnt + 1;
      if (remaining < tol) begin
        travelled = path_len;
        speed_now = 0;
        move_done = 1'b1;
      end else begin
        lhs = 2 * accel_lim * remaining;
        rhs = speed_now * speed_now;
        dv = (accel_lim * dt) >> 16;
        nt = travelled + ((speed_now * dt) >> 16);
        travelled = (nt > path_len) ? path_len : nt;
        if (lhs > rhs) speed_now = speed_now + dv;
        else speed_now = (dv >= speed_now) ? 64'd0 : speed_now - dv;
        if (speed_now > speed_lim) speed_now = speed_lim;
        if (step_cnt >= step_lim) begin
          speed_now = 0;
          move_done = 1'b1;
        end
      end
    end
    for (int i = 0; i < 3; i++) begin
      if (travelled >= path_len) raw[i] = tgt[i];
      else begin
        m = (travelled * dir_mag[i]) >> 30;
        raw[i] = dir_neg[i] ? (64'd0 - m) : m;
      end
    end
    res.px = raw[0][31:0];
    res.py = raw[1][31:0];
    res.pz = raw[2][31:0];
    res.speed = speed_now[23:0];
    res.arrived = (path_len - travelled) < tol;
    res.timed_out = step_cnt >= step_lim;
    return res;
  endfunction

  task automatic report(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at cycle %0d", field, got, want, cycles);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    motion_cmd_t c;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        setpoint_q = {setpoint_q,
                      advance_profile(in_mode, in_target_x, in_target_y, in_target_z)};
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (cmd_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 11) == 0) begin
          send_gap = $urandom_range(1, 18) - 1;
          in_valid <= 1'b0;
        end else begin
          c = cmd_q.pop_front();
          in_valid <= 1'b1;
          in_mode <= c.mode;
          in_target_x <= c.x;
          in_target_y <= c.y;
          in_target_z <= c.z;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    setpoint_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (setpoint_q.size() == 0) begin
          $display("unexpected transaction at cycle %0d", cycles);
          errors++;
        end else begin
          e = setpoint_q.pop_front();
          if (out_pos_x !== e.px) report("pos_x", out_pos_x, e.px);
          if (out_pos_y !== e.py) report("pos_y", out_pos_y, e.py);
          if (out_pos_z !== e.pz) report("pos_z", out_pos_z, e.pz);
          if (out_speed_out !== e.speed) report("speed_out", out_speed_out, e.speed);
          if (out_arrived !== e.arrived) report("arrived", out_arrived, e.arrived);
          if (out_timed_out !== e.timed_out) report("timed_out", out_timed_out, e.timed_out);
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        recv_stall = $urandom_range(1, 18) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic queue_load(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    motion_cmd_t c;
    c.mode = 1'b0;
    c.x = x;
    c.y = y;
    c.z = z;
    cmd_q = {cmd_q, c};
  endtask

  task automatic queue_ticks(int n);
    motion_cmd_t c;
    c.mode = 1'b1;
    for (int i = 0; i < n; i++) begin
      c.x = $urandom;
      c.y = $urandom;
      c.z = $urandom;
      cmd_q = {cmd_q, c};
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (cmd_q.size() != 0 || in_valid || setpoint_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [tlp_pkg::IDX_WIDTH-1:0] idx,
                           logic [tlp_pkg::CFG_WIDTH-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    unique case (idx)
      tlp_pkg::REG_ACCEL_LIMIT: accel_lim = val;
      tlp_pkg::REG_SPEED_LIMIT: speed_lim = val;
      tlp_pkg::REG_STEP_TIME:   dt = val[15:0];
      tlp_pkg::REG_ARRIVE_TOL:  tol = val;
      tlp_pkg::REG_STEP_LIMIT:  step_lim = val[19:0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [23:0] a, logic [23:0] s, logic [23:0] t, logic [23:0] tl,
                           logic [23:0] lim);
    wait_idle();
    write_reg(tlp_pkg::REG_ACCEL_LIMIT, a);
    write_reg(tlp_pkg::REG_SPEED_LIMIT, s);
    write_reg(tlp_pkg::REG_STEP_TIME, t);
    write_reg(tlp_pkg::REG_ARRIVE_TOL, tl);
    write_reg(tlp_pkg::REG_STEP_LIMIT, lim);
    write_reg(REG_FIRST_UNUSED + tlp_pkg::IDX_WIDTH'($urandom_range(0, 2)),
              tlp_pkg::CFG_WIDTH'($urandom));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] near_coord();
    logic [31:0] v;
    v = $urandom_range(0, 4) == 0 ? 32'd0 : 32'($urandom_range(0, 32'h000C_0000));
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  task automatic random_moves(int n);
    int sent;
    int k;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 9) < 8) begin
        queue_load(near_coord(), near_coord(), near_coord());
        k = $urandom_range(1, 30);
      end else if ($urandom_range(0, 1)) begin
        queue_load($urandom, $urandom, $urandom);
        k = $urandom_range(0, 3);
      end else begin
        k = $urandom_range(1, 3);
      end
      queue_ticks(k);
      sent += k + 1;
    end
  endtask

  initial begin
    accel_lim = 655360;
    speed_lim = 131072;
    dt = 655;
    tol = 655;
    step_lim = 100000;
    travelled = 0;
    speed_now = 0;
    path_len = 0;
    step_cnt = 0;
    for (int i = 0; i < 3; i++) begin
      dir_mag[i] = 0;
      dir_neg[i] = 1'b0;
      tgt[i] = 0;
    end
    move_done = 1'b1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // held state before any load, zero path, extreme targets
    queue_ticks(1);
    queue_load(0, 0, 0);
    queue_ticks(2);
    queue_load(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    queue_ticks(2);
    queue_load(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    queue_ticks(1);
    queue_load(32'h8000_0000, 32'h7FFF_FFFF, 0);
    queue_ticks(3);
    queue_load(32'h0001_0000, 0, 0);
    queue_ticks(5);
    random_moves(40);

    configure(24'h40_0000, 24'h10_0000, 24'hFFFF, 655, 100000);
    random_moves(70);
    configure(24'hFF_FFFF, 24'hFF_FFFF, 24'hFFFF, 24'hFF_FFFF, 24'h0F_FFFF);
    random_moves(50);
    configure(0, 0, 0, 0, 0);
    random_moves(30);
    configure(24'h10_0000, 24'h20_0000, 24'h8000, 0, 20);
    random_moves(50);
    configure(24'($urandom), 24'($urandom), 24'($urandom_range(0, 65535)),
              24'($urandom_range(0, 1 << 18)), 24'($urandom_range(1, 200)));
    random_moves(60);
    configure(24'h40_0000, 24'h10_0000, 24'hFFFF, 24'h1000, 64);
    quiet = 1'b1;
    random_moves(60);

    wait_idle();
    if (errors == 0) begin
      $display("trapezoidal_line_profile regression: pass");
    end else begin
      $display("trapezoidal_line_profile regression: fail");
    end
    $finish;
  end

endmodule
